// ----- rtl/core/pvd_pkg.sv -----
// Package for the prefix varint decoder: kind codes, prefix constants,
// the result record passed to the output register, and the sign-extension helper.
// It has no dependencies.
package pvd_pkg;

    typedef enum logic [1:0] {
        KIND_U32 = 2'd0,
        KIND_U64 = 2'd1,
        KIND_S32 = 2'd2,
        KIND_S64 = 2'd3
    } kind_t;

    localparam logic [7:0] PFX_U_MAX = 8'd252;
    localparam logic [7:0] PFX_U_2   = 8'd253;
    localparam logic [7:0] PFX_U_4   = 8'd254;
    localparam logic [7:0] PFX_S_MAX = 8'd124;
    localparam logic [7:0] PFX_S_2   = 8'd125;
    localparam logic [7:0] PFX_S_4   = 8'd126;

    localparam logic [3:0] LEN_2 = 4'd2;
    localparam logic [3:0] LEN_4 = 4'd4;
    localparam logic [3:0] LEN_8 = 4'd8;

    typedef struct packed {
        logic        valid;
        logic [63:0] value;
        logic        error;
    } pvd_result_t;

    function automatic logic kind_is_signed(input logic [1:0] k);
        return (k == KIND_S32) || (k == KIND_S64);
    endfunction

    function automatic logic kind_is_64(input logic [1:0] k);
        return (k == KIND_U64) || (k == KIND_S64);
    endfunction

    function automatic logic [63:0] sign_extend(input logic [63:0] v, input logic [3:0] len);
        logic [63:0] r;
        r = v;
        if (len == LEN_2) begin
            r = {{48{v[15]}}, v[15:0]};
        end else if (len == LEN_4) begin
            r = {{32{v[31]}}, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/pvd_assembler.sv -----
// Decode state and byte assembly for the prefix varint decoder.
// It tracks the payload bytes still due and builds each value; depends on pvd_pkg.
module pvd_assembler
    import pvd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  byte_in,
    input  logic [1:0]  kind,
    output pvd_result_t result
);

    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [3:0]  payload_len_reg, payload_len_next;
    logic [63:0] accumulator_reg, accumulator_next;
    logic [1:0]  kind_reg, kind_next;

    logic        is_short;
    logic [3:0]  len;
    logic [3:0]  offset;
    logic [63:0] acc_or;

    always_comb begin
        bytes_left_next  = bytes_left_reg;
        payload_len_next = payload_len_reg;
        accumulator_next = accumulator_reg;
        kind_next        = kind_reg;
        result           = '0;
        is_short         = 1'b0;
        len              = LEN_8;
        offset           = payload_len_reg - bytes_left_reg;
        acc_or           = accumulator_reg | ({56'd0, byte_in} << {offset[2:0], 3'b000});

        if (kind_is_signed(kind)) begin
            is_short = (byte_in <= PFX_S_MAX) || byte_in[7];
            if (byte_in == PFX_S_2) begin
                len = LEN_2;
            end else if (byte_in == PFX_S_4) begin
                len = LEN_4;
            end
        end else begin
            is_short = (byte_in <= PFX_U_MAX);
            if (byte_in == PFX_U_2) begin
                len = LEN_2;
            end else if (byte_in == PFX_U_4) begin
                len = LEN_4;
            end
        end

        if (accept) begin
            if (bytes_left_reg == 4'd0) begin
                kind_next        = kind;
                accumulator_next = '0;
                if (is_short) begin
                    result.valid = 1'b1;
                    result.value = kind_is_signed(kind) ? {{56{byte_in[7]}}, byte_in}
                                                        : {56'd0, byte_in};
                end else if ((len == LEN_8) && !kind_is_64(kind)) begin
                    result.valid     = 1'b1;
                    result.error     = 1'b1;
                    payload_len_next = 4'd0;
                end else begin
                    payload_len_next = len;
                    bytes_left_next  = len;
                end
            end else begin
                accumulator_next = acc_or;
                bytes_left_next  = bytes_left_reg - 4'd1;
                if (bytes_left_reg == 4'd1) begin
                    result.valid = 1'b1;
                    result.value = kind_is_signed(kind_reg)
                                   ? sign_extend(acc_or, payload_len_reg) : acc_or;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg  <= '0;
            payload_len_reg <= '0;
            kind_reg        <= '0;
        end else begin
            bytes_left_reg  <= bytes_left_next;
            payload_len_reg <= payload_len_next;
            kind_reg        <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        accumulator_reg <= accumulator_next;
    end

endmodule

// ----- rtl/core/pvd_out_reg.sv -----
// Result register of the prefix varint decoder, holding one finished result.
// It accepts a new result in the cycle the held one is transferred; depends on pvd_pkg.
module pvd_out_reg
    import pvd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pvd_result_t result,
    output logic        space,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_error
);

    logic        valid_reg, valid_next;
    logic [63:0] value_reg, value_next;
    logic        error_reg, error_next;

    assign space = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg && !m_ready;
        value_next = value_reg;
        error_next = error_reg;
        if (result.valid) begin
            valid_next = 1'b1;
            value_next = result.value;
            error_next = result.error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        error_reg <= error_next;
    end

    assign m_valid = valid_reg;
    assign m_value = value_reg;
    assign m_error = error_reg;

endmodule

// ----- rtl/core/prefix_varint_decoder_unit.sv -----
// Prefix varint decoder: at most one stream byte per cycle in, one decoded value per value out.
// A result appears in the cycle after the transfer of its last byte; the input takes a byte
// every cycle while the result register is empty or is being read, set by that register.
// Reset is synchronous and active low; it clears the decode state and the result valid.
// Builds on pvd_pkg, pvd_assembler and pvd_out_reg.
module prefix_varint_decoder_unit
    import pvd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic [1:0]  s_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_error
);

    pvd_result_t result;
    logic        accept;

    assign accept = s_valid && s_ready;

    pvd_assembler u_assembler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .byte_in (s_byte_in),
        .kind    (s_kind),
        .result  (result)
    );

    pvd_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .result  (result),
        .space   (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value),
        .m_error (m_error)
    );

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_value == 64'd0)
        else $error("error result carries a non-zero value");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty result register");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for prefix_varint_decoder_unit: byte streams of prefixed integers
// in all four kinds go in, and each decoded value and error flag is checked against a predictor.
// Depends on pvd_pkg for the kind codes and the prefix constants.
module testbench
    import pvd_pkg::*;
();

    localparam logic [7:0] PFX_U_8 = 8'd255;
    localparam logic [7:0] PFX_S_8 = 8'd127;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [63:0] value;
        logic        error;
    } decoded_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in = 8'd0;
    logic [1:0]  s_kind = KIND_U32;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_value;
    logic        m_error;

    decoded_t    decoded_q[$];
    int          failures = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    bit          sender_idles = 1'b1;
    bit          receiver_stalls = 1'b1;

    logic [3:0]  pend_bytes = 4'd0;
    logic [3:0]  pend_len = 4'd0;
    logic [63:0] pend_acc = 64'd0;
    kind_t       pend_kind = KIND_U32;

    prefix_varint_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .s_kind    (s_kind),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_error   (m_error)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void push_decoded(input logic [63:0] value, input logic error);
        decoded_t d;
        d.value = value;
        d.error = error;
        decoded_q.insert(decoded_q.size(), d);
    endfunction

    // Advances the decode state by one transferred byte and queues any value it completes.
    function automatic void decode_byte(input logic [7:0] b, input kind_t k);
        logic       is_signed;
        logic       is_wide;
        logic [3:0] len;
        logic [2:0] idx;
        logic [63:0] v;
        if (pend_bytes == 4'd0) begin
            is_signed = (k == KIND_S32) || (k == KIND_S64);
            is_wide = (k == KIND_U64) || (k == KIND_S64);
            pend_kind = k;
            pend_acc = 64'd0;
            len = 4'd0;
            if (!is_signed) begin
                if (b <= PFX_U_MAX) push_decoded({56'd0, b}, 1'b0);
                else if (b == PFX_U_2) len = LEN_2;
                else if (b == PFX_U_4) len = LEN_4;
                else len = LEN_8;
            end else begin
                if (b[7] || b <= PFX_S_MAX) push_decoded({{56{b[7]}}, b}, 1'b0);
                else if (b == PFX_S_2) len = LEN_2;
                else if (b == PFX_S_4) len = LEN_4;
                else len = LEN_8;
            end
            if (len == LEN_8 && !is_wide) begin
                pend_len = 4'd0;
                push_decoded(64'd0, 1'b1);
            end else if (len != 4'd0) begin
                pend_len = len;
                pend_bytes = len;
            end
        end else begin
            idx = 3'(pend_len - pend_bytes);
            pend_acc = pend_acc | ({56'd0, b} << (8 * idx));
            pend_bytes = pend_bytes - 4'd1;
            if (pend_bytes == 4'd0) begin
                v = pend_acc;
                if (pend_kind == KIND_S32 || pend_kind == KIND_S64) begin
                    if (pend_len == LEN_2) v = {{48{pend_acc[15]}}, pend_acc[15:0]};
                    else if (pend_len == LEN_4) v = {{32{pend_acc[31]}}, pend_acc[31:0]};
                end
                push_decoded(v, 1'b0);
            end
        end
    endfunction

    // Called at a rising edge; returns at the edge where the byte is transferred.
    task automatic send_byte(input logic [7:0] b, input kind_t k);
        while (sender_idles && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_in <= b;
        s_kind <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(b, k);
        bytes_sent++;
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_value();
        kind_t      k;
        logic       is_signed;
        logic [7:0] pfx;
        int         pick;
        int         n_pay;
        k = kind_t'($urandom_range(0, 3));
        is_signed = (k == KIND_S32) || (k == KIND_S64);
        pick = $urandom_range(0, 9);
        n_pay = 0;
        if (pick < 4) begin
            pfx = 8'($urandom_range(0, 252));
            if (is_signed && pfx > PFX_S_MAX) pfx = pfx + 8'd3;
        end else if (pick < 6) begin
            pfx = is_signed ? PFX_S_2 : PFX_U_2;
            n_pay = 2;
        end else if (pick < 8) begin
            pfx = is_signed ? PFX_S_4 : PFX_U_4;
            n_pay = 4;
        end else begin
            pfx = is_signed ? PFX_S_8 : PFX_U_8;
            n_pay = (k == KIND_U64 || k == KIND_S64) ? 8 : 0;
        end
        send_byte(pfx, k);
        for (int i = 0; i < n_pay; i++) send_byte(payload_byte(), kind_t'($urandom_range(0, 3)));
    endtask

    task automatic send_mixed_traffic(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 9) == 0) send_byte(payload_byte(), kind_t'($urandom_range(0, 3)));
            else send_random_value();
        end
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_one_byte_values();
        send_byte(8'd0, KIND_U32);
        send_byte(PFX_U_MAX, KIND_U32);
        send_byte(PFX_U_8, KIND_U32);
        send_byte(8'h80, KIND_S32);
        send_byte(PFX_S_MAX, KIND_S32);
        send_byte(PFX_S_8, KIND_S32);
    endtask

    // The kind changes during the payload bytes, which must not affect the value.
    task automatic test_payload_values();
        send_byte(PFX_U_2, KIND_U64);
        send_byte(8'hFF, KIND_S32);
        send_byte(8'hFF, KIND_U32);
        send_byte(PFX_S_4, KIND_S32);
        send_byte(8'h00, KIND_U64);
        send_byte(8'h00, KIND_U32);
        send_byte(8'h00, KIND_S64);
        send_byte(8'h80, KIND_U64);
        send_byte(PFX_S_8, KIND_S64);
        send_byte(8'h01, KIND_U32);
        send_byte(8'h23, KIND_U64);
        send_byte(8'h45, KIND_S32);
        send_byte(8'h67, KIND_U32);
        send_byte(8'h89, KIND_U32);
        send_byte(8'hAB, KIND_U64);
        send_byte(8'hCD, KIND_S32);
        send_byte(8'hEF, KIND_U32);
    endtask

    task automatic test_random_traffic();
        send_mixed_traffic(900);
    endtask

    task automatic test_back_to_back();
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        send_mixed_traffic(300);
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_drained_bursts();
        for (int burst = 0; burst < 4; burst++) begin
            for (int i = 0; i < 12; i++) send_random_value();
            wait_for_drain();
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= receiver_stalls ? ($urandom_range(0, 99) >= 14) : 1'b1;
    end

    always @(posedge aclk) begin
        decoded_t exp_d;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result value=%h error=%b", $time, m_value, m_error);
                failures++;
            end else begin
                exp_d = decoded_q.pop_front();
                if (m_value !== exp_d.value) begin
                    $display("%0t: value expected %h actual %h", $time, exp_d.value, m_value);
                    failures++;
                end
                if (m_error !== exp_d.error) begin
                    $display("%0t: error expected %b actual %b", $time, exp_d.error, m_error);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_one_byte_values();
        test_payload_values();
        test_random_traffic();
        test_back_to_back();
        test_drained_bursts();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
